[rtl/ps2_mouse_packet_tracker_defines.svh]
// assertion macros shared by the tracker rtl
`ifndef PS2_MOUSE_PACKET_TRACKER_DEFINES_SVH
`define PS2_MOUSE_PACKET_TRACKER_DEFINES_SVH

// antecedent in a cycle implies consequent in the same cycle
`define PS2MT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ps2 tracker check failed");

// antecedent in a cycle implies consequent in the next cycle
`define PS2MT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ps2 tracker check failed");

`endif

[rtl/ps2mt_pkg.sv]
// types and constants of the ps2 mouse packet tracker
package ps2mt_pkg;

   localparam int CoordBitsDefault = 12;
   localparam int FieldBits        = 12;
   localparam int CsrIndexBits     = 3;

   localparam int MaxXReset  = 1023;
   localparam int MaxYReset  = 767;
   localparam int HomeXReset = 512;
   localparam int HomeYReset = 384;

   localparam int SyncBit = 3;

   typedef enum logic [CsrIndexBits-1:0] {
      CSR_MAX_X  = 3'd0,
      CSR_MAX_Y  = 3'd1,
      CSR_HOME_X = 3'd2,
      CSR_HOME_Y = 3'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      PHASE_SYNC = 2'd0,
      PHASE_DX   = 2'd1,
      PHASE_DY   = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       from_aux;
   } req_payload_type;

   typedef struct packed {
      logic [FieldBits-1:0] pointer_x;
      logic [FieldBits-1:0] pointer_y;
   } rsp_payload_type;

   typedef struct packed {
      logic            emit;
      rsp_payload_type point;
   } core_result_type;

endpackage

[rtl/ps2mt_core.sv]
// packet framing, position state and add-and-clamp
`include "ps2_mouse_packet_tracker_defines.svh"

module ps2mt_core #(
   parameter int COORD_BITS = ps2mt_pkg::CoordBitsDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  ps2mt_pkg::req_payload_type item,
   input  logic [COORD_BITS-1:0]     max_x,
   input  logic [COORD_BITS-1:0]     max_y,
   output ps2mt_pkg::core_result_type result
);

   localparam int SumBits = COORD_BITS + 2;

   ps2mt_pkg::phase_type  phase_ff, phase_in;
   logic [7:0]            dx_ff, dx_in;
   logic [COORD_BITS-1:0] pos_x_ff, pos_x_in;
   logic [COORD_BITS-1:0] pos_y_ff, pos_y_in;

   logic signed [SumBits-1:0] sum_x;
   logic signed [SumBits-1:0] sum_y;
   logic [COORD_BITS-1:0]     clamp_x;
   logic [COORD_BITS-1:0]     clamp_y;

   // x gains dx, y loses dy since screen y points down
   always_comb begin
      sum_x = signed'({2'b00, pos_x_ff}) + SumBits'(signed'(dx_ff));
      sum_y = signed'({2'b00, pos_y_ff}) - SumBits'(signed'(item.rx_byte));
      if (sum_x < 0) begin
         clamp_x = '0;
      end else if (sum_x > signed'({2'b00, max_x})) begin
         clamp_x = max_x;
      end else begin
         clamp_x = sum_x[COORD_BITS-1:0];
      end
      if (sum_y < 0) begin
         clamp_y = '0;
      end else if (sum_y > signed'({2'b00, max_y})) begin
         clamp_y = max_y;
      end else begin
         clamp_y = sum_y[COORD_BITS-1:0];
      end
   end

   always_comb begin
      phase_in = phase_ff;
      dx_in    = dx_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      result.emit            = item.from_aux && (phase_ff == ps2mt_pkg::PHASE_DY);
      result.point.pointer_x = ps2mt_pkg::FieldBits'(clamp_x);
      result.point.pointer_y = ps2mt_pkg::FieldBits'(clamp_y);
      if (step && item.from_aux) begin
         case (phase_ff)
            ps2mt_pkg::PHASE_DX: begin
               dx_in    = item.rx_byte;
               phase_in = ps2mt_pkg::PHASE_DY;
            end
            ps2mt_pkg::PHASE_DY: begin
               phase_in = ps2mt_pkg::PHASE_SYNC;
               pos_x_in = clamp_x;
               pos_y_in = clamp_y;
            end
            default: begin
               // a first byte without the sync bit is dropped to resync
               phase_in = item.rx_byte[ps2mt_pkg::SyncBit] ? ps2mt_pkg::PHASE_DX
                                                           : ps2mt_pkg::PHASE_SYNC;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ps2mt_pkg::PHASE_SYNC;
         dx_ff    <= '0;
         pos_x_ff <= COORD_BITS'(ps2mt_pkg::HomeXReset);
         pos_y_ff <= COORD_BITS'(ps2mt_pkg::HomeYReset);
      end else begin
         phase_ff <= phase_in;
         dx_ff    <= dx_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
      end
   end

   `PS2MT_ASSERT_NEXT(a_sync_after_emit, clock, reset, step && result.emit,
                      phase_ff == ps2mt_pkg::PHASE_SYNC)
   `PS2MT_ASSERT_NEXT(a_dx_held, clock, reset, !(step && item.from_aux), $stable(dx_ff))

endmodule

[rtl/ps2_mouse_packet_tracker.sv]
// top level of the ps2 mouse packet tracker
//
// Bytes from the ps2 auxiliary port come in on the req channel, one beat per
// byte; bytes with from_aux low are dropped. Three-byte packets are framed,
// the first byte must carry bit 3 or it is discarded. Each completed packet
// gives one rsp beat with the clamped pointer position.
// The csr channel writes max_x and max_y; home_x and home_y writes are taken
// and dropped, and csr_ready is always high. The home values are the reset
// position only, so later home writes leave the pointer where it is.
// Throughput is one byte per cycle unless a third byte waits for the output
// register: a byte is held in the input register, where the add-and-clamp
// and the state update take place, and the result is loaded into the output
// register, which drives rsp_valid.
// When the receiver stalls, bytes that give no result keep flowing; a third
// byte waits in the input register until the output register is free.
// Reset is synchronous: packet framing restarts, limits return to 1023 and
// 767, and the pointer goes to 512, 384.
`include "ps2_mouse_packet_tracker_defines.svh"

module ps2_mouse_packet_tracker #(
   parameter int COORD_BITS = ps2mt_pkg::CoordBitsDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  ps2mt_pkg::req_payload_type           req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output ps2mt_pkg::rsp_payload_type           rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ps2mt_pkg::CsrIndexBits-1:0]   csr_index,
   input  logic [ps2mt_pkg::FieldBits-1:0]      csr_wdata
);

   logic                       in_valid_ff, in_valid_in;
   ps2mt_pkg::req_payload_type in_data_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   ps2mt_pkg::rsp_payload_type rsp_data_ff;
   logic [COORD_BITS-1:0]      max_x_ff;
   logic [COORD_BITS-1:0]      max_y_ff;

   ps2mt_pkg::core_result_type result;
   logic                       in_advance;
   logic                       load_rsp;
   logic [COORD_BITS-1:0]      csr_value;

   ps2mt_core #(
      .COORD_BITS(COORD_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (in_advance),
      .item   (in_data_ff),
      .max_x  (max_x_ff),
      .max_y  (max_y_ff),
      .result (result)
   );

   // a byte that gives a result needs the output register free
   assign in_advance = in_valid_ff && (!result.emit || !rsp_valid_ff || rsp_ready);
   assign load_rsp   = in_advance && result.emit;
   assign req_ready  = !in_valid_ff || in_advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (load_rsp) begin
         rsp_data_ff <= result.point;
      end
   end

   // home values are reset values only, so home writes are taken and dropped
   assign csr_ready = 1'b1;
   assign csr_value = COORD_BITS'(csr_wdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_x_ff <= COORD_BITS'(ps2mt_pkg::MaxXReset);
         max_y_ff <= COORD_BITS'(ps2mt_pkg::MaxYReset);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ps2mt_pkg::CSR_MAX_X: max_x_ff <= csr_value;
            ps2mt_pkg::CSR_MAX_Y: max_y_ff <= csr_value;
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `PS2MT_ASSERT_SAME(a_stall_cause, clock, reset, in_valid_ff && !in_advance,
                      rsp_valid_ff && !rsp_ready && result.emit)
   `PS2MT_ASSERT_NEXT(a_result_loaded, clock, reset, load_rsp, rsp_valid_ff)
   `PS2MT_ASSERT_SAME(a_empty_ready, clock, reset, !in_valid_ff, req_ready)

endmodule
